// ===== rtl/core/fpla_pkg.sv =====
// ----------------------------------------------------------------------------
// fpla_pkg: shared constants for the free page list allocator
// Page geometry, counter widths, command and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpla_pkg;

    // page geometry
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_PAGES  = 65536;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int ADDR_W     = 32;
    localparam int GRANT_W    = 28;
    localparam int LIMIT_W    = 29;
    localparam int PAGE_TOP   = PAGE_SHIFT + PAGE_W;

    // list end marker and saturation limit
    localparam logic [CNT_W-1:0] NULL_PAGE = CNT_W'(MAX_PAGES);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PAGE = 2'd1;
    localparam logic [1:0] ST_BAD_ADR = 2'd2;

    // register indexes
    localparam logic REG_LOW_LIMIT = 1'b0;
    localparam logic REG_PHYS_TOP  = 1'b1;

    localparam logic [LIMIT_W-1:0] PHYS_TOP_RST = LIMIT_W'(268435456);

endpackage

`default_nettype wire

// ===== rtl/core/free_page_list_allocator.sv =====
// Result: each accepted word gives its result word on m_tdata in the next cycle.
// Throughput: one word per cycle while the result stream is not stalled; the link
// of the head page is kept ready by a registered read of the link memory at the
// next head every cycle. Reset: list empty, both counts zero, low_limit 0, phys_top
// 2^28; the link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// free_page_list_allocator: LIFO free page list with alloc and free commands
// Pops or pushes one page per word, checks free addresses against the limits
// and reports free and allocated counts with every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module free_page_list_allocator
    import fpla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] page_address
    input  wire logic        s_tuser,   // [0] cmd
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [27:0] granted_address, [44:28] free_count,
                                        // [61:45] allocated_count, [62] has_free
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [LIMIT_W-1:0] low_limit_reg;
    logic [LIMIT_W-1:0] phys_top_reg;

    logic [CNT_W-1:0]   head_reg,  head_next;
    logic [CNT_W-1:0]   link_reg,  link_next;
    logic               link_src_reg, link_src_next;
    logic [CNT_W-1:0]   free_reg,  free_next;
    logic [CNT_W-1:0]   used_reg,  used_next;

    logic               out_valid_reg;
    logic [1:0]         status_reg,  status_next;
    logic [GRANT_W-1:0] grant_reg,   grant_next;

    logic [CNT_W-1:0]   link_mem [MAX_PAGES];
    logic [CNT_W-1:0]   rd_data_reg;
    logic               wr_en;
    logic [PAGE_W-1:0]  wr_addr;

    logic               accept;
    logic               cfg_wr;
    logic [CNT_W-1:0]   link_cur;
    logic               bad_free;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  grant_wide;

    // handshake
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign addr     = s_tdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg <= '0;
            phys_top_reg  <= PHYS_TOP_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LOW_LIMIT)
                low_limit_reg <= pwdata[LIMIT_W-1:0];
            else
                phys_top_reg  <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PHYS_TOP)
            prdata = {{(32-LIMIT_W){1'b0}}, phys_top_reg};
        else
            prdata = {{(32-LIMIT_W){1'b0}}, low_limit_reg};
    end

    // link of the current head: fresh memory read after a pop, held value otherwise
    assign link_cur = link_src_reg ? rd_data_reg : link_reg;

    // free address check
    assign bad_free = (addr[PAGE_SHIFT-1:0] != '0)
                   || (addr < ADDR_W'(low_limit_reg))
                   || (addr >= ADDR_W'(phys_top_reg))
                   || ((addr >> PAGE_TOP) != '0);

    assign grant_wide = ADDR_W'(head_reg[PAGE_W-1:0]) << PAGE_SHIFT;

    // list update and result
    always_comb
    begin
        head_next     = head_reg;
        link_next     = link_reg;
        link_src_next = link_src_reg;
        free_next     = free_reg;
        used_next     = used_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        wr_en         = 1'b0;
        wr_addr       = addr[PAGE_SHIFT +: PAGE_W];
        if (accept)
        begin
            status_next = ST_OK;
            grant_next  = '0;
            case (s_tuser)
                CMD_ALLOC:
                begin
                    if (head_reg != NULL_PAGE)
                    begin
                        head_next     = link_cur;
                        link_src_next = 1'b1;
                        grant_next    = grant_wide[GRANT_W-1:0];
                        used_next     = (used_reg >= NULL_PAGE) ? NULL_PAGE : used_reg + 1'b1;
                        free_next     = (free_reg == '0) ? '0 : free_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = ST_NO_PAGE;
                    end
                end
                CMD_FREE:
                begin
                    if (bad_free)
                    begin
                        status_next = ST_BAD_ADR;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        head_next     = CNT_W'(addr[PAGE_SHIFT +: PAGE_W]);
                        link_next     = head_reg;
                        link_src_next = 1'b0;
                        used_next     = (used_reg == '0) ? '0 : used_reg - 1'b1;
                        free_next     = (free_reg >= NULL_PAGE) ? NULL_PAGE : free_reg + 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // link memory, read at the next head every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= head_reg;
        rd_data_reg <= link_mem[head_next[PAGE_W-1:0]];
    end

    // list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= NULL_PAGE;
            link_reg     <= NULL_PAGE;
            link_src_reg <= 1'b0;
            free_reg     <= '0;
            used_reg     <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            link_reg     <= link_next;
            link_src_reg <= link_src_next;
            free_reg     <= free_next;
            used_reg     <= used_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, (head_reg != NULL_PAGE), used_reg, free_reg, grant_reg};

endmodule

`default_nettype wire

// ===== tb/free_page_list_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_page_list_allocator_test: self-checking bench for the page allocator
// Drives alloc and free words through the input stream under several limit
// settings, predicts every result word from its own copy of the free list and
// compares each field of the result stream, with random gaps on both sides.
// ----------------------------------------------------------------------------

module free_page_list_allocator_test;
    import fpla_pkg::*;

    // expected contents of one result word
    typedef struct packed {
        logic [1:0]         status;
        logic [GRANT_W-1:0] granted;
        logic [CNT_W-1:0]   free_cnt;
        logic [CNT_W-1:0]   used_cnt;
        logic               has_free;
    } grant_word_t;

    // free list model and queue of result words still to arrive
    class page_grant_tracker;
        logic [CNT_W-1:0]   next_page [MAX_PAGES];
        logic [CNT_W-1:0]   head;
        logic [CNT_W-1:0]   free_total;
        logic [CNT_W-1:0]   used_pages;
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] phys_top;
        grant_word_t        pending_grants [$];
        int unsigned        mismatches;

        function new();
            head       = NULL_PAGE;
            free_total = '0;
            used_pages = '0;
            low_limit  = '0;
            phys_top   = PHYS_TOP_RST;
            mismatches = 0;
        endfunction

        function void set_limit(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_LOW_LIMIT)
                low_limit = value[LIMIT_W-1:0];
            else
                phys_top = value[LIMIT_W-1:0];
        endfunction

        function logic [CNT_W-1:0] count_inc(logic [CNT_W-1:0] c);
            return (c >= CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : c + 1'b1;
        endfunction

        function logic [CNT_W-1:0] count_dec(logic [CNT_W-1:0] c);
            return (c == '0) ? '0 : c - 1'b1;
        endfunction

        // pop or push the list for one accepted word
        function void note_request(logic cmd, logic [ADDR_W-1:0] adr);
            grant_word_t      w;
            logic [CNT_W-1:0] page;
            logic [63:0]      wide;
            bit               reject;
            w = '0;
            if (cmd == CMD_ALLOC)
            begin
                if (head != NULL_PAGE)
                begin
                    page       = head;
                    head       = next_page[page[PAGE_W-1:0]];
                    used_pages = count_inc(used_pages);
                    free_total = count_dec(free_total);
                    wide       = 64'(page) << PAGE_SHIFT;
                    w.granted  = wide[GRANT_W-1:0];
                end
                else
                    w.status = ST_NO_PAGE;
            end
            else
            begin
                reject = (adr[PAGE_SHIFT-1:0] != '0) ||
                         (adr < ADDR_W'(low_limit)) ||
                         (adr >= ADDR_W'(phys_top)) ||
                         ((adr >> PAGE_SHIFT) >= ADDR_W'(MAX_PAGES));
                if (reject)
                    w.status = ST_BAD_ADR;
                else
                begin
                    next_page[adr[PAGE_TOP-1:PAGE_SHIFT]] = head;
                    head       = {1'b0, adr[PAGE_TOP-1:PAGE_SHIFT]};
                    used_pages = count_dec(used_pages);
                    free_total = count_inc(free_total);
                end
            end
            w.free_cnt = free_total;
            w.used_cnt = used_pages;
            w.has_free = (head != NULL_PAGE);
            pending_grants.push_back(w);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare one result word with the oldest expectation
        function void check_grant(logic [63:0] data, logic [1:0] user);
            grant_word_t want;
            if (pending_grants.size() == 0)
            begin
                $display("%0t: result word with none expected, expected nothing, actual %h/%h",
                         $time, data, user);
                mismatches++;
                return;
            end
            want = pending_grants.pop_front();
            compare_field("status", 32'(want.status), 32'(user));
            compare_field("granted_address", 32'(want.granted), 32'(data[27:0]));
            compare_field("free_count", 32'(want.free_cnt), 32'(data[44:28]));
            compare_field("allocated_count", 32'(want.used_cnt), 32'(data[61:45]));
            compare_field("has_free", 32'(want.has_free), 32'(data[62]));
        endfunction
    endclass

    localparam int IDLE_LIMIT = 4000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;      // [31:0] page_address
    logic        s_tuser  = 1'b0;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [27:0] granted_address, [44:28] free_count,
                                     // [61:45] allocated_count, [62] has_free
    logic [1:0]  m_tuser;            // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    page_grant_tracker ledger = new();
    bit                steady_flow = 1'b0;

    free_page_list_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gap length: mostly none or short, a few long
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // one input word, after an optional gap
    task automatic send_word(logic cmd, logic [ADDR_W-1:0] adr);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= adr;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        ledger.note_request(cmd, adr);
    endtask

    // register write: setup then access, then back to idle
    task automatic write_reg(logic reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_limit(reg_idx, value);
        @(posedge clk);
    endtask

    // wait for every outstanding result, then let the pipe settle
    task automatic drain();
        while (ledger.pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random word: mostly allocs and good frees, some rejected frees
    task automatic send_random();
        int unsigned     pick;
        int unsigned     lo_pg;
        int unsigned     hi_pg;
        int unsigned     span;
        int unsigned     pg;
        bit              has_range;
        logic [31:0]     adr;
        pick      = $urandom_range(0, 99);
        adr       = $urandom();
        lo_pg     = (32'(ledger.low_limit) + 32'd4095) >> PAGE_SHIFT;
        hi_pg     = (ledger.phys_top == '0) ? 0 : (32'(ledger.phys_top) - 1) >> PAGE_SHIFT;
        has_range = (ledger.phys_top != '0) && (lo_pg <= hi_pg);
        span      = has_range ? hi_pg - lo_pg : 0;
        pg        = lo_pg;
        if (has_range)
        begin
            // a small window keeps pages recycling and freed twice
            if ($urandom_range(0, 2) != 0)
                pg = lo_pg + $urandom_range(0, (span > 31) ? 31 : span);
            else
                pg = $urandom_range(lo_pg, hi_pg);
        end
        if (pick < 45)
            send_word(CMD_ALLOC, adr);
        else if (pick < 85 && has_range)
            send_word(CMD_FREE, pg << PAGE_SHIFT);
        else
        begin
            case ($urandom_range(0, 3))
                // misaligned
                0: adr = (pg << PAGE_SHIFT) | $urandom_range(1, 4095);
                // below the lower limit
                2: if (ledger.low_limit != '0)
                       adr = ((32'(ledger.low_limit) - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
                // at or above the top, sometimes beyond the store
                3: adr = (((32'(ledger.phys_top) + 32'd4095) >> PAGE_SHIFT)
                          + $urandom_range(0, 3)) << PAGE_SHIFT;
                default: ;
            endcase
            send_word(CMD_FREE, adr);
        end
    endtask

    // result side: random stalls, check every accepted word
    initial
    begin
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                ledger.check_grant(m_tdata, m_tuser);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int unsigned idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pwrite && pready) || !rst_n)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned n_rand;
        logic [31:0] lo;
        logic [31:0] hi;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 8; ph++)
        begin
            steady_flow = (ph == 2) || (ph == 5);
            case (ph)
                0:
                begin
                    // reset limits: empty list, edges of the address range
                    n_rand = 120;
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_FREE, 32'h0000_0000);
                    send_word(CMD_FREE, 32'h0000_0801);
                    send_word(CMD_FREE, 32'h0FFF_F000);
                    send_word(CMD_FREE, 32'h1000_0000);
                    send_word(CMD_FREE, 32'hFFFF_F000);
                    send_word(CMD_FREE, 32'hFFFF_FFFF);
                    send_word(CMD_ALLOC, 32'hFFFF_FFFF);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    // same page freed twice
                    send_word(CMD_FREE, 32'h0000_5000);
                    send_word(CMD_FREE, 32'h0000_5000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_FREE, 32'h0000_1FFF);
                end
                1:
                begin
                    // upper register bits are dropped
                    n_rand = 120;
                    write_reg(REG_LOW_LIMIT, 32'hE010_0000);
                    write_reg(REG_PHYS_TOP, 32'h0020_0000);
                    send_word(CMD_FREE, 32'h000F_F000);
                    send_word(CMD_FREE, 32'h0010_0000);
                    send_word(CMD_FREE, 32'h001F_F000);
                    send_word(CMD_FREE, 32'h0020_0000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                    send_word(CMD_ALLOC, 32'h0000_0000);
                end
                2:
                begin
                    n_rand = 50;
                    write_reg(REG_LOW_LIMIT, 32'h0000_0000);
                    write_reg(REG_PHYS_TOP, 32'h0000_0000);
                end
                3:
                begin
                    n_rand = 50;
                    write_reg(REG_LOW_LIMIT, 32'h1000_0000);
                    write_reg(REG_PHYS_TOP, 32'h1000_0000);
                end
                4:
                begin
                    n_rand = 160;
                    write_reg(REG_LOW_LIMIT, 32'h0000_0000);
                    write_reg(REG_PHYS_TOP, 32'h1000_0000);
                end
                5:
                begin
                    n_rand = 150;
                    lo = $urandom_range(0, 32'h800) << PAGE_SHIFT;
                    hi = lo + ($urandom_range(1, 64) << PAGE_SHIFT);
                    write_reg(REG_LOW_LIMIT, lo);
                    write_reg(REG_PHYS_TOP, hi);
                end
                6:
                begin
                    n_rand = 100;
                    write_reg(REG_LOW_LIMIT, 32'h0FFF_0000);
                    write_reg(REG_PHYS_TOP, 32'h1000_0000);
                end
                default:
                begin
                    // unaligned limits
                    n_rand = 100;
                    lo = $urandom_range(0, 32'h0FFF_0000);
                    hi = lo + $urandom_range(0, 32'h0010_0000);
                    if (hi > 32'h1000_0000)
                        hi = 32'h1000_0000;
                    write_reg(REG_LOW_LIMIT, lo);
                    write_reg(REG_PHYS_TOP, hi);
                end
            endcase

            repeat (n_rand) send_random();

            // sender holds off until every result is back
            s_tvalid <= 1'b0;
            drain();
        end

        if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
